// File: src/ftc_pkg.sv
// Shared types and constants for the fan tach frequency calculator
`timescale 1ns / 1ps
package ftc_pkg;

    localparam int NUM_CAPTURES = 4;
    localparam int PERIOD_W     = 32;
    localparam int CLOCK_W      = 28;
    localparam int FRAC_SHIFT   = 14;
    localparam int FREQ_W       = CLOCK_W + FRAC_SHIFT;
    localparam int SAMPLE_W     = 3;
    localparam int CNT_W        = $clog2(NUM_CAPTURES + 1);
    localparam int SUM_W        = PERIOD_W + $clog2(NUM_CAPTURES);
    localparam int Q2_W         = SUM_W + 2;
    localparam int AVG_W        = PERIOD_W + 2;

    localparam int AVG_DIG      = 4;
    localparam int AVG_STEPS    = (Q2_W + AVG_DIG - 1) / AVG_DIG;
    localparam int AVG_PAD_W    = AVG_STEPS * AVG_DIG;
    localparam int AVG_STEP_W   = $clog2(AVG_STEPS + 1);
    localparam int AVG_REM_W    = CNT_W + 1;

    localparam int FREQ_STEP_W  = $clog2(FREQ_W + 1);
    localparam int FREQ_REM_W   = AVG_W + 1;

    localparam int CFG_W        = 32;
    localparam int CFG_IDX_W    = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPTURE_LIMIT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_HZ      = CFG_IDX_W'(1);

    localparam logic [PERIOD_W-1:0] LIMIT_RESET = 32'd80740352;
    localparam logic [CLOCK_W-1:0]  CLOCK_RESET = 28'd80000000;

    typedef enum logic [1:0] {
        ST_VALID     = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_NO_SAMPLE = 2'd2
    } t_status;

    typedef struct packed {
        logic                counter_overflow;
        logic                valid_0;
        logic                valid_1;
        logic                valid_2;
        logic                valid_3;
        logic [PERIOD_W-1:0] period_0;
        logic [PERIOD_W-1:0] period_1;
        logic [PERIOD_W-1:0] period_2;
        logic [PERIOD_W-1:0] period_3;
    } t_in_req;

    typedef struct packed {
        logic [FREQ_W-1:0]   frequency_q12;
        t_status             status;
        logic [SAMPLE_W-1:0] sample_count;
    } t_res;

    typedef struct packed {
        logic             ovf;
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] count;
    } t_merge;

    typedef struct packed {
        logic             ovf;
        logic [AVG_W-1:0] avg;
        logic [CNT_W-1:0] count;
    } t_avg;

endpackage

// File: src/ftc_lane.sv
// One capture lane: qualifies a reading against the limit and registers it
`timescale 1ns / 1ps
module ftc_lane (
    input  logic                         i_clk,
    input  logic                         i_load,
    input  logic                         i_valid_bit,
    input  logic [ftc_pkg::PERIOD_W-1:0] i_period,
    input  logic [ftc_pkg::PERIOD_W-1:0] i_limit,
    output logic                         o_used,
    output logic [ftc_pkg::PERIOD_W-1:0] o_period
);
    import ftc_pkg::*;

    logic                r_used;
    logic [PERIOD_W-1:0] r_period;
    logic                w_hit;

    assign w_hit = i_valid_bit && (i_period < i_limit);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_used   <= w_hit;
            r_period <= w_hit ? i_period : '0;
        end
    end

    assign o_used   = r_used;
    assign o_period = r_period;

endmodule

// File: src/ftc_merge.sv
// Merge stage: sums the lane periods and counts the used lanes
`timescale 1ns / 1ps
module ftc_merge (
    input  logic                                                 i_clk,
    input  logic                                                 i_rst_n,
    input  logic                                                 i_valid,
    output logic                                                 o_ready,
    input  logic                                                 i_ovf,
    input  logic [ftc_pkg::NUM_CAPTURES-1:0]                     i_used,
    input  logic [ftc_pkg::NUM_CAPTURES-1:0][ftc_pkg::PERIOD_W-1:0] i_period,
    output logic                                                 o_valid,
    input  logic                                                 i_ready,
    output ftc_pkg::t_merge                                      o_data
);
    import ftc_pkg::*;

    logic             r_valid;
    t_merge           r_data;
    logic [SUM_W-1:0] n_sum;
    logic [CNT_W-1:0] n_count;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        n_sum   = '0;
        n_count = '0;
        for (int k = 0; k < NUM_CAPTURES; k++) begin
            n_sum   = n_sum + SUM_W'(i_period[k]);
            n_count = n_count + CNT_W'(i_used[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data.ovf   <= i_ovf;
            r_data.sum   <= n_sum;
            r_data.count <= n_count;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// File: src/ftc_avg_div.sv
// Average divider: 4*sum / count, several quotient bits per cycle
`timescale 1ns / 1ps
module ftc_avg_div (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  ftc_pkg::t_merge i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output ftc_pkg::t_avg   o_data
);
    import ftc_pkg::*;

    logic                  r_busy;
    logic                  r_done;
    logic                  r_ovf;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      r_div;
    logic [AVG_REM_W-1:0]  r_rem;
    logic [AVG_PAD_W-1:0]  r_quo;
    logic [AVG_STEP_W-1:0] r_step;
    logic [AVG_REM_W-1:0]  n_rem;
    logic [AVG_PAD_W-1:0]  n_quo;
    logic                  w_accept;
    logic                  w_skip;

    assign o_ready  = !r_busy && (!r_done || i_ready);
    assign w_accept = i_valid && o_ready;
    assign w_skip   = i_data.ovf || (i_data.count == '0);

    always_comb begin
        logic [AVG_REM_W-1:0] rem;
        logic [AVG_PAD_W-1:0] quo;
        rem = r_rem;
        quo = r_quo;
        for (int k = 0; k < AVG_DIG; k++) begin
            rem = {rem[AVG_REM_W-2:0], quo[AVG_PAD_W-1]};
            quo = {quo[AVG_PAD_W-2:0], 1'b0};
            if (rem >= {1'b0, r_div}) begin
                rem    = rem - {1'b0, r_div};
                quo[0] = 1'b1;
            end
        end
        n_rem = rem;
        n_quo = quo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (w_accept) begin
            r_busy <= !w_skip;
            r_done <= w_skip;
        end else if (r_busy && (r_step == '0)) begin
            r_busy <= 1'b0;
            r_done <= 1'b1;
        end else if (r_done && i_ready) begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ovf   <= i_data.ovf;
            r_count <= i_data.count;
            r_div   <= i_data.count;
            r_rem   <= '0;
            r_quo   <= w_skip ? '0 : AVG_PAD_W'({i_data.sum, 2'b00});
            r_step  <= AVG_STEP_W'(AVG_STEPS - 1);
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_quo  <= n_quo;
            r_step <= r_step - 1'b1;
        end
    end

    assign o_valid      = r_done;
    assign o_data.ovf   = r_ovf;
    assign o_data.avg   = r_quo[AVG_W-1:0];
    assign o_data.count = r_count;

endmodule

// File: src/ftc_freq_div.sv
// Frequency divider: clock_hz*2^14 / avg_q2, one quotient bit per cycle
`timescale 1ns / 1ps
module ftc_freq_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  ftc_pkg::t_avg               i_data,
    input  logic [ftc_pkg::CLOCK_W-1:0] i_clock_hz,
    output logic                        o_valid,
    input  logic                        i_ready,
    output ftc_pkg::t_res               o_res
);
    import ftc_pkg::*;

    logic                   r_busy;
    logic                   r_done;
    t_status                r_status;
    logic [CNT_W-1:0]       r_count;
    logic [AVG_W-1:0]       r_div;
    logic [FREQ_REM_W-1:0]  r_rem;
    logic [FREQ_W-1:0]      r_quo;
    logic [FREQ_STEP_W-1:0] r_step;
    logic [FREQ_REM_W-1:0]  w_shift;
    logic                   w_ge;
    logic                   w_accept;
    logic                   w_no_sample;
    logic                   w_skip;

    assign o_ready     = !r_busy && (!r_done || i_ready);
    assign w_accept    = i_valid && o_ready;
    assign w_no_sample = (i_data.count == '0) || (i_data.avg == '0);
    assign w_skip      = i_data.ovf || w_no_sample;

    assign w_shift = {r_rem[FREQ_REM_W-2:0], r_quo[FREQ_W-1]};
    assign w_ge    = w_shift >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (w_accept) begin
            r_busy <= !w_skip;
            r_done <= w_skip;
        end else if (r_busy && (r_step == '0)) begin
            r_busy <= 1'b0;
            r_done <= 1'b1;
        end else if (r_done && i_ready) begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_div  <= i_data.avg;
            r_rem  <= '0;
            r_step <= FREQ_STEP_W'(FREQ_W - 1);
            if (i_data.ovf) begin
                r_status <= ST_OVERFLOW;
                r_count  <= '0;
                r_quo    <= '0;
            end else if (w_no_sample) begin
                r_status <= ST_NO_SAMPLE;
                r_count  <= i_data.count;
                r_quo    <= '0;
            end else begin
                r_status <= ST_VALID;
                r_count  <= i_data.count;
                r_quo    <= {i_clock_hz, FRAC_SHIFT'(0)};
            end
        end else if (r_busy) begin
            r_rem  <= w_ge ? (w_shift - {1'b0, r_div}) : w_shift;
            r_quo  <= {r_quo[FREQ_W-2:0], w_ge};
            r_step <= r_step - 1'b1;
        end
    end

    assign o_valid             = r_done;
    assign o_res.frequency_q12 = r_quo;
    assign o_res.status        = r_status;
    assign o_res.sample_count  = SAMPLE_W'(r_count);

`ifndef NO_ASSERTIONS
    a_ovf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_res.status == ST_OVERFLOW)) |->
        ((o_res.frequency_q12 == '0) && (o_res.sample_count == '0)))
        else $error("overflow result not zeroed");

    a_busy_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_busy && r_done))
        else $error("divider busy while holding a result");

    a_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && (r_step == '0)) |=> (o_valid && (o_res.status == ST_VALID)))
        else $error("divide finished without a valid result");

    a_valid_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_res.status == ST_VALID)) |-> (r_count != '0))
        else $error("valid result with no samples");
`endif

endmodule

// File: src/fan_tach_frequency_calc_core.sv
// Top level of the fan tach frequency calculator
`timescale 1ns / 1ps
// Each request is a snapshot of four capture readings plus an overflow flag; one
// result comes back per request, in order. The lanes and the merge stage take a
// new request every cycle unless the stage after them holds them back. Each divider
// works on one request at a time and takes no new one until it is done; the
// frequency divider resolves one quotient bit per cycle, so with the output taken
// promptly its loop sets the throughput. Overflow and no-sample requests skip the
// divide loop in each divider. Register writes are expected only while no request
// is in flight.
module fan_tach_frequency_calc_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  ftc_pkg::t_in_req              i_req,
    output logic                          o_valid,
    input  logic                          i_ready,
    output ftc_pkg::t_res                 o_res,
    input  logic                          i_cfg_we,
    input  logic [ftc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ftc_pkg::CFG_W-1:0]     i_cfg_data
);
    import ftc_pkg::*;

    logic [PERIOD_W-1:0] r_limit;
    logic [CLOCK_W-1:0]  r_clock_hz;
    logic                r_a_valid;
    logic                r_a_ovf;
    logic                w_accept;

    logic [NUM_CAPTURES-1:0]               w_in_valid;
    logic [NUM_CAPTURES-1:0][PERIOD_W-1:0] w_in_period;
    logic [NUM_CAPTURES-1:0]               w_used;
    logic [NUM_CAPTURES-1:0][PERIOD_W-1:0] w_lane_period;

    logic   w_m_ready;
    logic   w_m_valid;
    t_merge w_m_data;
    logic   w_v_ready;
    logic   w_v_valid;
    t_avg   w_v_data;
    logic   w_f_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit    <= LIMIT_RESET;
            r_clock_hz <= CLOCK_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CAPTURE_LIMIT: r_limit    <= i_cfg_data[PERIOD_W-1:0];
                CFG_CLOCK_HZ:      r_clock_hz <= i_cfg_data[CLOCK_W-1:0];
                default: ;
            endcase
        end
    end

    // snapshot fields into lane order
    assign w_in_valid  = {i_req.valid_3, i_req.valid_2, i_req.valid_1, i_req.valid_0};
    assign w_in_period = {i_req.period_3, i_req.period_2, i_req.period_1, i_req.period_0};

    assign o_ready  = !r_a_valid || w_m_ready;
    assign w_accept = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (o_ready) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_a_ovf <= i_req.counter_overflow;
        end
    end

    for (genvar g = 0; g < NUM_CAPTURES; g++) begin : g_lane
        ftc_lane u_lane (
            .i_clk       (i_clk),
            .i_load      (w_accept),
            .i_valid_bit (w_in_valid[g]),
            .i_period    (w_in_period[g]),
            .i_limit     (r_limit),
            .o_used      (w_used[g]),
            .o_period    (w_lane_period[g])
        );
    end

    ftc_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_a_valid),
        .o_ready  (w_m_ready),
        .i_ovf    (r_a_ovf),
        .i_used   (w_used),
        .i_period (w_lane_period),
        .o_valid  (w_m_valid),
        .i_ready  (w_v_ready),
        .o_data   (w_m_data)
    );

    ftc_avg_div u_avg_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_m_valid),
        .o_ready (w_v_ready),
        .i_data  (w_m_data),
        .o_valid (w_v_valid),
        .i_ready (w_f_ready),
        .o_data  (w_v_data)
    );

    ftc_freq_div u_freq_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_v_valid),
        .o_ready    (w_f_ready),
        .i_data     (w_v_data),
        .i_clock_hz (r_clock_hz),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_res      (o_res)
    );

endmodule
